[rtl/kest_pkg.sv]
// ----------------------------------------------------------------------------
// kest_pkg
// Shared constants for the key event slot tracker: request kinds, register
// indexes, key phase codes, fixed field widths and mask reset values.
// ----------------------------------------------------------------------------
package kest_pkg;

  localparam int KeyW  = 4;
  localparam int MaskW = 16;
  localparam int KEYS  = 16;

  localparam int CfgIdxW = 1;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_KEY_MASK = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_INV_MASK = 1'b1;

  // request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_FETCH  = 1'b1;

  // key phases
  localparam logic [1:0] PH_OFF     = 2'd0;
  localparam logic [1:0] PH_DOWN    = 2'd1;
  localparam logic [1:0] PH_HOLDING = 2'd2;
  localparam logic [1:0] PH_UP      = 2'd3;

  localparam logic [MaskW-1:0] KEY_MASK_RST = 16'hFFFF;
  localparam logic [MaskW-1:0] INV_MASK_RST = 16'h0000;

endpackage

[rtl/key_event_slot_tracker.sv]
// ----------------------------------------------------------------------------
// key_event_slot_tracker
// Tracks pressed keys in a small slot table and reports phase changes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries two kinds of request.
//   A sample request gives one key's raw level; it updates the slot that
//   holds the key (or claims a free one if the key is pressed) and yields
//   no result. A fetch request yields exactly one result on the output
//   channel (out_valid_o / out_stall_i): the next used, triggered slot at
//   or after the read pointer, or event_valid_o low when none is left.
//   The slot table is searched by one compare unit, one slot per cycle.
//   A sample scans every slot and then updates the chosen one; a sample
//   for a disabled key is dropped without a scan. A fetch scans from the
//   read pointer until its result is in the output register. in_stall_o is
//   high while a request is worked on.
//   The output register lets a new request enter while a result waits. A
//   fetch that finishes while the receiver still stalls the previous result
//   holds its scan position until the register frees.
//   Reset empties all slots, clears triggers and the read pointer, enables
//   all keys and sets all keys active high. Write the masks only when idle.
// ----------------------------------------------------------------------------
module key_event_slot_tracker #(
  parameter int SLOTS        = 4,
  parameter int HISTORY_BITS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [kest_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [kest_pkg::MaskW-1:0]           cfg_data_i,
  // requests
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 req_type_i,
  input  logic [kest_pkg::KeyW-1:0]            key_id_i,
  input  logic                                 level_i,
  input  logic                                 scan_last_i,
  // results
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 event_valid_o,
  output logic [kest_pkg::KeyW-1:0]            event_key_o,
  output logic [1:0]                           event_state_o
);

  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PtrW  = $clog2(SLOTS + 1);
  localparam logic [PtrW-1:0]  PtrEnd   = PtrW'(SLOTS);
  localparam logic [SlotW-1:0] SlotLast = SlotW'(SLOTS - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_FETCH  = 2'd3;

  logic [1:0] state_q, state_d;

  logic [kest_pkg::MaskW-1:0] key_mask_q, key_mask_d;
  logic [kest_pkg::MaskW-1:0] inv_mask_q, inv_mask_d;

  logic                        used_q  [SLOTS];
  logic                        used_d  [SLOTS];
  logic [kest_pkg::KeyW-1:0]   skey_q  [SLOTS];
  logic [kest_pkg::KeyW-1:0]   skey_d  [SLOTS];
  logic [HISTORY_BITS-1:0]     hist_q  [SLOTS];
  logic [HISTORY_BITS-1:0]     hist_d  [SLOTS];
  logic [1:0]                  phase_q [SLOTS];
  logic [1:0]                  phase_d [SLOTS];
  logic                        trig_q  [SLOTS];
  logic                        trig_d  [SLOTS];

  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [PtrW-1:0] idx_q, idx_d;

  logic [kest_pkg::KeyW-1:0] req_key_q, req_key_d;
  logic                      pressed_q, pressed_d;
  logic [SlotW-1:0]          found_q, found_d;
  logic                      found_ok_q, found_ok_d;
  logic [SlotW-1:0]          empty_q, empty_d;
  logic                      empty_ok_q, empty_ok_d;

  logic                      out_valid_q, out_valid_d;
  logic                      ev_valid_q, ev_valid_d;
  logic [kest_pkg::KeyW-1:0] ev_key_q, ev_key_d;
  logic [1:0]                ev_state_q, ev_state_d;

  logic                      accept;
  logic                      key_ok;
  logic                      out_free;
  logic [SlotW-1:0]          cur;
  logic [SlotW-1:0]          sel;
  logic                      do_upd;
  logic [HISTORY_BITS:0]     hcat;
  logic [HISTORY_BITS-1:0]   h_new;
  logic [1:0]                ph_new;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cur        = idx_q[SlotW-1:0];

  assign key_ok = ({1'b0, key_id_i} < 5'(kest_pkg::KEYS)) && key_mask_q[key_id_i];

  // slot chosen at the update step: holder of the key first, else a free one
  assign sel    = found_ok_q ? found_q : empty_q;
  assign do_upd = found_ok_q || (pressed_q && empty_ok_q);
  assign hcat   = {hist_q[sel], pressed_q};
  assign h_new  = hcat[HISTORY_BITS-1:0];

  always_comb begin
    case (phase_q[sel])
      kest_pkg::PH_OFF:     ph_new = (|h_new) ? kest_pkg::PH_DOWN : kest_pkg::PH_OFF;
      kest_pkg::PH_DOWN:    ph_new = (|h_new) ? kest_pkg::PH_HOLDING : kest_pkg::PH_UP;
      kest_pkg::PH_HOLDING: ph_new = (|h_new) ? kest_pkg::PH_HOLDING : kest_pkg::PH_UP;
      default:              ph_new = kest_pkg::PH_OFF;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    key_mask_d  = key_mask_q;
    inv_mask_d  = inv_mask_q;
    used_d      = used_q;
    skey_d      = skey_q;
    hist_d      = hist_q;
    phase_d     = phase_q;
    trig_d      = trig_q;
    rptr_d      = rptr_q;
    idx_d       = idx_q;
    req_key_d   = req_key_q;
    pressed_d   = pressed_q;
    found_d     = found_q;
    found_ok_d  = found_ok_q;
    empty_d     = empty_q;
    empty_ok_d  = empty_ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    ev_valid_d  = ev_valid_q;
    ev_key_d    = ev_key_q;
    ev_state_d  = ev_state_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        kest_pkg::CFG_KEY_MASK: key_mask_d = cfg_data_i;
        kest_pkg::CFG_INV_MASK: inv_mask_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d = '0;
          if (req_type_i == kest_pkg::REQ_FETCH) begin
            idx_d   = rptr_q;
            state_d = ST_FETCH;
          end else begin
            req_key_d  = key_id_i;
            pressed_d  = level_i ^ inv_mask_q[key_id_i];
            found_ok_d = 1'b0;
            empty_ok_d = 1'b0;
            found_d    = '0;
            empty_d    = '0;
            if (scan_last_i) begin
              rptr_d = '0;
            end
            if (key_ok) begin
              state_d = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        if (used_q[cur] && (skey_q[cur] == req_key_q) && !found_ok_q) begin
          found_d    = cur;
          found_ok_d = 1'b1;
        end
        if (!used_q[cur] && !empty_ok_q) begin
          empty_d    = cur;
          empty_ok_d = 1'b1;
        end
        if (cur == SlotLast) begin
          state_d = ST_UPDATE;
        end else begin
          idx_d = idx_q + PtrW'(1);
        end
      end

      ST_UPDATE: begin
        if (do_upd) begin
          if (!found_ok_q) begin
            skey_d[sel] = req_key_q;
          end
          used_d[sel]  = (phase_q[sel] != kest_pkg::PH_UP);
          hist_d[sel]  = h_new;
          phase_d[sel] = ph_new;
          if (ph_new != phase_q[sel]) begin
            trig_d[sel] = 1'b1;
          end
        end
        state_d = ST_IDLE;
      end

      ST_FETCH: begin
        if (idx_q >= PtrEnd) begin
          // nothing left in this scan
          if (out_free) begin
            out_valid_d = 1'b1;
            ev_valid_d  = 1'b0;
            ev_key_d    = '0;
            ev_state_d  = kest_pkg::PH_OFF;
            rptr_d      = PtrEnd;
            state_d     = ST_IDLE;
          end
        end else if (used_q[cur] && trig_q[cur]) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            ev_valid_d  = 1'b1;
            ev_key_d    = skey_q[cur];
            ev_state_d  = phase_q[cur];
            trig_d[cur] = 1'b0;
            rptr_d      = idx_q + PtrW'(1);
            state_d     = ST_IDLE;
          end
        end else begin
          idx_d = idx_q + PtrW'(1);
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_mask_q  <= kest_pkg::KEY_MASK_RST;
      inv_mask_q  <= kest_pkg::INV_MASK_RST;
      rptr_q      <= '0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        used_q[s]  <= 1'b0;
        skey_q[s]  <= '0;
        hist_q[s]  <= '0;
        phase_q[s] <= kest_pkg::PH_OFF;
        trig_q[s]  <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      key_mask_q  <= key_mask_d;
      inv_mask_q  <= inv_mask_d;
      rptr_q      <= rptr_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
      skey_q      <= skey_d;
      hist_q      <= hist_d;
      phase_q     <= phase_d;
      trig_q      <= trig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    req_key_q  <= req_key_d;
    pressed_q  <= pressed_d;
    found_q    <= found_d;
    found_ok_q <= found_ok_d;
    empty_q    <= empty_d;
    empty_ok_q <= empty_ok_d;
    ev_valid_q <= ev_valid_d;
    ev_key_q   <= ev_key_d;
    ev_state_q <= ev_state_d;
  end

  assign out_valid_o   = out_valid_q;
  assign event_valid_o = ev_valid_q;
  assign event_key_o   = ev_key_q;
  assign event_state_o = ev_state_q;

endmodule
